// ===== hw/rtl/aocba_pkg.sv =====
// Shared types and codes for the ADC offset calibration and bus averaging block.
`default_nettype none

package aocba_pkg;

	// Width of every sample, offset and bus average field on the ports
	localparam int FIELD_W    = 12;
	localparam int NUM_PHASES = 3;
	localparam int PHASE_W    = 2;

	// Phase select codes
	localparam logic [PHASE_W-1:0] PH_U = 2'd0;
	localparam logic [PHASE_W-1:0] PH_V = 2'd1;
	localparam logic [PHASE_W-1:0] PH_W = 2'd2;

	// Input beat: one synchronous sample set
	typedef struct packed {
		logic [FIELD_W-1:0] u_sample;
		logic [FIELD_W-1:0] v_sample;
		logic [FIELD_W-1:0] w_sample;
		logic [FIELD_W-1:0] bus_sample;
		logic               window_end;
		logic               cal_restart;
	} smp_beat_t;

	// Output beat: offsets and bus average after the sample
	typedef struct packed {
		logic [FIELD_W-1:0] u_offset_out;
		logic [FIELD_W-1:0] v_offset_out;
		logic [FIELD_W-1:0] w_offset_out;
		logic [FIELD_W-1:0] bus_avg_out;
		logic               cal_active;
		logic               bus_avg_new;
	} res_beat_t;

	// Controller to datapath commands
	typedef struct packed {
		logic               step;       // apply the incoming sample set
		logic               div_start;  // load divider with the selected phase sum
		logic               off_wr;     // store quotient as offset of the selected phase
		logic               out_load;   // capture result into output register
		logic [PHASE_W-1:0] phase;
	} aocba_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_req;   // incoming sample closes the calibration window
		logic div_busy;  // divider iterating
	} aocba_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aocba_div.sv =====
// Restoring divider, one quotient bit per cycle, for the offset means.
`default_nettype none

module aocba_div #(
	parameter int Q_W = 12,
	parameter int D_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [Q_W+D_W-1:0] dividend,
	input  wire logic [D_W-1:0]   divisor,
	output logic                  busy,
	output logic [Q_W-1:0]        quotient
);
	localparam int CNT_W = $clog2(Q_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q;
	logic [Q_W-1:0]   low_q;

	logic [D_W:0] trial;
	logic [D_W:0] diff;
	logic         ge;

	// Quotient fits Q_W bits, so the top D_W dividend bits start below the divisor
	assign trial = {rem_q, low_q[Q_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	// Control: step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[Q_W+D_W-1:Q_W];
			low_q <= dividend[Q_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			low_q <= {low_q[Q_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = low_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aocba_dp.sv =====
// Datapath: calibration sums, offsets, bus block average and result register.
`default_nettype none

module aocba_dp #(
	parameter int ADC_BITS       = 12,
	parameter int BUS_AVG_LOG2   = 7,
	parameter int CAL_COUNT_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  aocba_pkg::smp_beat_t   smp,
	input  aocba_pkg::aocba_cmd_t  cmd,
	output aocba_pkg::aocba_stat_t stat,
	output aocba_pkg::res_beat_t   res
);
	import aocba_pkg::*;

	localparam int SUM_W  = ADC_BITS + CAL_COUNT_BITS;
	localparam int BSUM_W = ADC_BITS + BUS_AVG_LOG2;

	logic                      cal_q;
	logic [SUM_W-1:0]          sum_q [NUM_PHASES];
	logic [CAL_COUNT_BITS-1:0] cnt_q;
	logic [ADC_BITS-1:0]       off_q [NUM_PHASES];
	logic [BSUM_W-1:0]         bsum_q;
	logic [BUS_AVG_LOG2-1:0]   bcnt_q;
	logic [ADC_BITS-1:0]       bavg_q;
	logic                      bnew_q;
	res_beat_t                 res_q;

	logic [ADC_BITS-1:0]       ph [NUM_PHASES];
	logic [ADC_BITS-1:0]       bus;
	logic                      cal_eff;
	logic                      room;
	logic [CAL_COUNT_BITS-1:0] cnt_base;
	logic [CAL_COUNT_BITS-1:0] cnt_nxt;
	logic [SUM_W-1:0]          sum_nxt [NUM_PHASES];
	logic [BSUM_W-1:0]         bsum_nxt;
	logic [SUM_W-1:0]          div_dividend;
	logic                      div_busy;
	logic [ADC_BITS-1:0]       quo;

	// Samples masked to the converter width
	assign ph[0] = ADC_BITS'(smp.u_sample);
	assign ph[1] = ADC_BITS'(smp.v_sample);
	assign ph[2] = ADC_BITS'(smp.w_sample);
	assign bus   = ADC_BITS'(smp.bus_sample);

	// Restart clears before the sample; saturated count stops accumulation
	assign cal_eff  = smp.cal_restart | cal_q;
	assign cnt_base = smp.cal_restart ? '0 : cnt_q;
	assign room     = cal_eff && (cnt_base != '1);
	assign cnt_nxt  = room ? cnt_base + 1'b1 : cnt_base;

	always_comb begin
		for (int i = 0; i < NUM_PHASES; i++) begin
			sum_nxt[i] = smp.cal_restart ? '0 : sum_q[i];
			if (room) begin
				sum_nxt[i] = sum_nxt[i] + SUM_W'(ph[i]);
			end
		end
	end

	assign bsum_nxt = bsum_q + BSUM_W'(bus);

	assign stat.div_req  = cal_eff & smp.window_end;
	assign stat.div_busy = div_busy;

	// Calibration state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= 1'b1;
			cnt_q <= '0;
			for (int i = 0; i < NUM_PHASES; i++) begin
				sum_q[i] <= '0;
			end
		end else if (cmd.step) begin
			cal_q <= cal_eff & ~smp.window_end;
			cnt_q <= cnt_nxt;
			for (int i = 0; i < NUM_PHASES; i++) begin
				sum_q[i] <= sum_nxt[i];
			end
		end
	end

	// Offsets written one phase at a time from the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PHASES; i++) begin
				off_q[i] <= '0;
			end
		end else if (cmd.off_wr) begin
			for (int i = 0; i < NUM_PHASES; i++) begin
				if (cmd.phase == PHASE_W'(i)) begin
					off_q[i] <= quo;
				end
			end
		end
	end

	// Bus block accumulator; counter wraps at the block length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsum_q <= '0;
			bcnt_q <= '0;
			bavg_q <= '0;
			bnew_q <= 1'b0;
		end else if (cmd.step) begin
			bcnt_q <= bcnt_q + 1'b1;
			if (&bcnt_q) begin
				bavg_q <= bsum_nxt[BSUM_W-1:BUS_AVG_LOG2];
				bsum_q <= '0;
				bnew_q <= 1'b1;
			end else begin
				bsum_q <= bsum_nxt;
				bnew_q <= 1'b0;
			end
		end
	end

	// Divider operand select
	always_comb begin
		case (cmd.phase)
			PH_U:    div_dividend = sum_q[0];
			PH_V:    div_dividend = sum_q[1];
			default: div_dividend = sum_q[2];
		endcase
	end

	aocba_div #(
		.Q_W (ADC_BITS),
		.D_W (CAL_COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (cnt_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.u_offset_out <= FIELD_W'(off_q[0]);
			res_q.v_offset_out <= FIELD_W'(off_q[1]);
			res_q.w_offset_out <= FIELD_W'(off_q[2]);
			res_q.bus_avg_out  <= FIELD_W'(bavg_q);
			res_q.cal_active   <= cal_q;
			res_q.bus_avg_new  <= bnew_q;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aocba_ctrl.sv =====
// Controller: beat handshake, divider sequencing over the phases, output valid.
`default_nettype none

module aocba_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              smp_valid,
	output logic                   smp_stall,
	output logic                   res_valid,
	input  wire logic              res_stall,
	input  aocba_pkg::aocba_stat_t stat,
	output aocba_pkg::aocba_cmd_t  cmd
);
	import aocba_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]         state_q;
	logic [PHASE_W-1:0] phase_q;
	logic               res_valid_q;
	logic               accept;
	logic               slot_free;

	assign accept    = smp_valid && (state_q == ST_IDLE);
	assign slot_free = !res_valid_q || !res_stall;

	// Commands
	always_comb begin
		cmd           = '0;
		cmd.phase     = phase_q;
		cmd.step      = accept;
		cmd.div_start = (state_q == ST_DIV);
		cmd.off_wr    = (state_q == ST_WAIT) && !stat.div_busy;
		cmd.out_load  = (state_q == ST_EMIT) && slot_free;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_U;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= stat.div_req ? ST_DIV : ST_EMIT;
					end
				end
				ST_DIV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!stat.div_busy) begin
						if (phase_q == PH_W) begin
							phase_q <= PH_U;
							state_q <= ST_EMIT;
						end else begin
							phase_q <= phase_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign smp_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/adc_offset_cal_and_bus_average_top.sv =====
// Timing: after an accepted sample beat the controller passes through ST_EMIT, where the
// result register loads once the output slot is free; when the beat closes the calibration
// window it first runs ST_DIV and ST_WAIT once per phase, on one shared bit-per-cycle
// divider. The input is stalled until the controller is back in ST_IDLE; a
// pending result in the output register does not block the next sample.
// Reset: arst_n asynchronous, active low; calibration starts active, sums cleared.
`default_nettype none

module adc_offset_cal_and_bus_average_top #(
	parameter int ADC_BITS       = 12,
	parameter int BUS_AVG_LOG2   = 7,
	parameter int CAL_COUNT_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            smp_valid,
	output logic                 smp_stall,
	input  aocba_pkg::smp_beat_t smp,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output aocba_pkg::res_beat_t res
);
	import aocba_pkg::*;

	aocba_cmd_t  cmd;
	aocba_stat_t stat;

	aocba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	aocba_dp #(
		.ADC_BITS       (ADC_BITS),
		.BUS_AVG_LOG2   (BUS_AVG_LOG2),
		.CAL_COUNT_BITS (CAL_COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

`ifndef NO_ASSERTIONS
	// Accepted beat blocks the input for at least the following cycle
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_stall |=> smp_stall)
		else $error("input not stalled after accepted beat");

	// Divider starts busy the cycle after a start command
	a_div_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> stat.div_busy)
		else $error("divider not busy after start");

	// Offset written only with a finished quotient
	a_off_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.off_wr |-> !stat.div_busy && !cmd.step)
		else $error("offset written while divider busy");

	// Taken result without reload leaves the output empty
	a_res_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !cmd.out_load |=> !res_valid)
		else $error("result beat repeated");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the ADC offset calibration and bus averaging block.
`timescale 1ns / 1ps

module testbench;
	import aocba_pkg::*;

	localparam int               LIMIT     = 2_000_000;
	localparam int               TAIL_WAIT = 60;
	localparam int               HOLD_LEN  = 300;
	localparam int               RAND_LEG  = 620;
	localparam int               BUS_BLOCK = 128;
	localparam int               BUS_SHIFT = 7;
	localparam logic [15:0]      CAL_MAX   = 16'hFFFF;
	localparam logic [FIELD_W-1:0] READ_MAX = '1;

	// Tracks calibration and bus averaging, and holds the result beats still owed
	class cal_tracker;
		bit                calibrating;
		logic [27:0]       phase_sum [NUM_PHASES];
		logic [15:0]       cal_count;
		logic [FIELD_W-1:0] phase_off [NUM_PHASES];
		logic [18:0]       bus_sum;
		logic [7:0]        bus_count;
		logic [FIELD_W-1:0] bus_avg;
		res_beat_t         owed_beats [$];
		int                errors;
		int                beats_seen;
		int                windows_closed;
		int                bus_blocks;
		int                sat_skipped;

		function new();
			calibrating = 1'b1;
			for (int i = 0; i < NUM_PHASES; i++) begin
				phase_sum[i] = '0;
				phase_off[i] = '0;
			end
			cal_count = '0;
			bus_sum   = '0;
			bus_count = '0;
			bus_avg   = '0;
		endfunction

		// Advance the state by one accepted sample beat and queue the result it owes
		function void add_sample(smp_beat_t s);
			logic [FIELD_W-1:0] ph [NUM_PHASES];
			logic [27:0]        quo;
			res_beat_t          r;
			ph[PH_U] = s.u_sample;
			ph[PH_V] = s.v_sample;
			ph[PH_W] = s.w_sample;
			r.bus_avg_new = 1'b0;

			// restart clears the sums before this sample is used
			if (s.cal_restart) begin
				calibrating = 1'b1;
				for (int i = 0; i < NUM_PHASES; i++) phase_sum[i] = '0;
				cal_count = '0;
			end

			if (calibrating) begin
				if (cal_count != CAL_MAX) begin
					for (int i = 0; i < NUM_PHASES; i++) phase_sum[i] += ph[i];
					cal_count++;
				end else begin
					sat_skipped++;
				end
				// window end: offsets become truncated means
				if (s.window_end) begin
					for (int i = 0; i < NUM_PHASES; i++) begin
						quo = phase_sum[i] / {12'd0, cal_count};
						phase_off[i] = quo[FIELD_W-1:0];
					end
					calibrating = 1'b0;
					windows_closed++;
				end
			end

			// bus block average, independent of calibration
			bus_sum += s.bus_sample;
			bus_count++;
			if (bus_count == BUS_BLOCK) begin
				bus_avg = bus_sum[BUS_SHIFT +: FIELD_W];
				bus_sum = '0;
				bus_count = '0;
				r.bus_avg_new = 1'b1;
				bus_blocks++;
			end

			r.u_offset_out = phase_off[PH_U];
			r.v_offset_out = phase_off[PH_V];
			r.w_offset_out = phase_off[PH_W];
			r.bus_avg_out  = bus_avg;
			r.cal_active   = calibrating;
			owed_beats.push_back(r);
		endfunction

		function void cmp_field(string name, int exp_v, int got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		// Compare one accepted result beat with the oldest owed beat
		function void check_beat(res_beat_t got);
			res_beat_t exp_r;
			if (owed_beats.size() == 0) begin
				$error("result beat with none owed");
				errors++;
				return;
			end
			exp_r = owed_beats.pop_front();
			beats_seen++;
			cmp_field("u_offset_out", exp_r.u_offset_out, got.u_offset_out);
			cmp_field("v_offset_out", exp_r.v_offset_out, got.v_offset_out);
			cmp_field("w_offset_out", exp_r.w_offset_out, got.w_offset_out);
			cmp_field("bus_avg_out", exp_r.bus_avg_out, got.bus_avg_out);
			cmp_field("cal_active", exp_r.cal_active, got.cal_active);
			cmp_field("bus_avg_new", exp_r.bus_avg_new, got.bus_avg_new);
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      smp_valid = 1'b0;
	logic      smp_stall;
	smp_beat_t smp       = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_beat_t res;

	cal_tracker sb = new();
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	bit         hold_req      = 1'b0;
	bit         hold_taken    = 1'b0;
	int         hold_left     = 0;
	int         cycle_count   = 0;

	adc_offset_cal_and_bus_average_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #6 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Result side: check accepted beats, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_beat(res);
		if (hold_req && !hold_taken) begin
			hold_left = HOLD_LEN;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic logic [FIELD_W-1:0] rand_reading();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return '0;
		if (sel == 1) return READ_MAX;
		return FIELD_W'($urandom_range(READ_MAX));
	endfunction

	function automatic smp_beat_t mk_sample(logic [FIELD_W-1:0] u, logic [FIELD_W-1:0] v,
			logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] bus, bit win_end, bit restart);
		smp_beat_t s;
		s.u_sample    = u;
		s.v_sample    = v;
		s.w_sample    = w;
		s.bus_sample  = bus;
		s.window_end  = win_end;
		s.cal_restart = restart;
		return s;
	endfunction

	function automatic smp_beat_t rand_sample(int end_pct, int restart_pct);
		return mk_sample(rand_reading(), rand_reading(), rand_reading(), rand_reading(),
			$urandom_range(99) < end_pct, $urandom_range(99) < restart_pct);
	endfunction

	// Offer one sample beat, with optional idle cycles first, and wait for acceptance
	task automatic send_beat(smp_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			smp_valid <= 1'b0;
			@(posedge clk);
		end
		smp_valid <= 1'b1;
		smp <= b;
		do @(posedge clk); while (smp_stall);
		sb.add_sample(b);
	endtask

	// Random calibration windows: restarts and window ends scattered over the stream
	task automatic send_random(int count);
		for (int k = 0; k < count; k++) send_beat(rand_sample(6, 4));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 38;
		recv_idle_pct = 46;

		// directed: extremes, window end, restarts, window end outside calibration
		send_beat(mk_sample('0, '0, '0, '0, 1'b0, 1'b0));
		send_beat(mk_sample(READ_MAX, READ_MAX, READ_MAX, READ_MAX, 1'b0, 1'b0));
		send_beat(mk_sample(READ_MAX, '0, 12'h800, 12'h001, 1'b1, 1'b0));
		send_beat(mk_sample(12'h123, 12'h456, 12'h789, 12'hABC, 1'b1, 1'b0));
		send_beat(mk_sample(12'hAAA, 12'h555, 12'hFFF, 12'h000, 1'b0, 1'b0));
		send_beat(mk_sample(READ_MAX, 12'h001, 12'h800, READ_MAX, 1'b1, 1'b1));
		send_beat(mk_sample('0, '0, '0, '0, 1'b0, 1'b1));
		send_beat(mk_sample(READ_MAX, READ_MAX, READ_MAX, '0, 1'b0, 1'b1));
		send_beat(mk_sample(READ_MAX, READ_MAX, READ_MAX, READ_MAX, 1'b1, 1'b0));
		send_beat(mk_sample('0, '0, '0, '0, 1'b0, 1'b1));
		send_beat(mk_sample('0, '0, '0, '0, 1'b1, 1'b0));
		send_beat(mk_sample(12'h555, 12'hAAA, 12'h555, 12'hAAA, 1'b0, 1'b1));
		send_beat(mk_sample(12'hAAA, 12'h555, 12'hAAA, 12'h555, 1'b0, 1'b0));
		send_beat(mk_sample(12'h001, 12'h002, 12'h7FF, 12'h800, 1'b1, 1'b0));
		send_beat(mk_sample(READ_MAX, READ_MAX, READ_MAX, READ_MAX, 1'b1, 1'b0));

		// long receiver hold-off so the block backs up into its input
		hold_req = 1'b1;
		send_random(RAND_LEG);

		send_idle_pct = 46;
		recv_idle_pct = 38;
		send_random(RAND_LEG);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(RAND_LEG);

		// closing window end, restart, window end back to back
		send_beat(rand_sample(100, 0));
		send_beat(rand_sample(0, 100));
		send_beat(rand_sample(100, 0));
		smp_valid <= 1'b0;

		// drain, then let the divider latency pass
		while (sb.owed_beats.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("covered %0d result beats, %0d calibration windows, %0d bus averages",
			sb.beats_seen, sb.windows_closed, sb.bus_blocks);
		$display("saturated count dropped %0d samples; %0d mismatches",
			sb.sat_skipped, sb.errors);
		if (sb.errors == 0 && sb.owed_beats.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// ===== adc_offset_cal_and_bus_average_top.f =====
hw/rtl/aocba_pkg.sv
hw/rtl/aocba_div.sv
hw/rtl/aocba_dp.sv
hw/rtl/aocba_ctrl.sv
hw/rtl/adc_offset_cal_and_bus_average_top.sv
dv/testbench.sv
